FILE: hw/rtl/qwma_pkg.sv
// Shared constants, types and helpers for the quadratic weighted moving average block.
// No dependencies; every other file of the block except qwma_ram uses this package.
`timescale 1ns / 1ps

package qwma_pkg;

    localparam int WINDOW   = 20;
    localparam int COORD_W  = 32;
    localparam int NUM_AXES = 3;
    localparam int POINT_W  = NUM_AXES * COORD_W;

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);

    // Weight (k+1)^2 and the full weight total.
    localparam int WGT_W   = $clog2(WINDOW * WINDOW + 1);
    localparam int WTOTAL  = WINDOW * (WINDOW + 1) * (2 * WINDOW + 1) / 6;
    localparam int HALF_WT = WTOTAL / 2;

    localparam int PROD_W = COORD_W + WGT_W + 1;
    localparam int REM_W  = $clog2(WTOTAL + 1);
    localparam int DVD_W  = COORD_W + REM_W;
    localparam int ACC_W  = DVD_W + 1;

    // Long division by the weight total, four quotient bits per cycle.
    localparam int BITS_PER_STEP = 4;
    localparam int DIV_STEPS     = COORD_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(DIV_STEPS);

    typedef logic signed [COORD_W-1:0]            t_coord;
    typedef logic [NUM_AXES-1:0][COORD_W-1:0]     t_coord_vec;
    typedef logic [NUM_AXES-1:0][ACC_W-1:0]       t_acc_vec;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DIV,
        S_LOAD
    } t_state;

    // Advance a window slot with wrap at the window size.
    function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] slot);
        slot_inc = (slot == IDX_W'(WINDOW - 1)) ? '0 : IDX_W'(slot + 1'b1);
    endfunction

endpackage

FILE: hw/rtl/quadratic_weighted_moving_average_3d_top.sv
// Quadratic weighted moving average of 3D positions; uses qwma_pkg, qwma_ram, qwma_div.
// Per input beat: read the F stored points (F = 1 to 20, oldest first), drain, divide
// (eight four-bit steps, then done), load, then back to idle. The input is stalled outside
//   idle, so one sample is worked on at a time; result stalls hold the load step.
// Reset: synchronous, active low; clears fill count, oldest slot and handshake state.
//   The point memory is not cleared: only slots already written are ever read.
`timescale 1ns / 1ps

module quadratic_weighted_moving_average_3d_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  qwma_pkg::t_coord i_sample_x,
    input  qwma_pkg::t_coord i_sample_y,
    input  qwma_pkg::t_coord i_sample_z,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output qwma_pkg::t_coord o_smooth_x,
    output qwma_pkg::t_coord o_smooth_y,
    output qwma_pkg::t_coord o_smooth_z
);
    import qwma_pkg::*;

    // Control state.
    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_fill;
    logic [IDX_W-1:0]   r_oldest;
    logic               r_v1;     // memory read data valid this cycle
    logic               r_v2;     // product register valid this cycle
    logic               r_out_valid;

    // Datapath registers.
    logic [CNT_W-1:0]                r_k;
    logic [IDX_W-1:0]                r_rd_slot;
    logic [WGT_W-1:0]                r_w1;
    logic [NUM_AXES-1:0][PROD_W-1:0] r_prod;
    t_acc_vec                        r_acc;
    t_coord_vec                      r_out;

    // Decoded controls.
    logic in_beat;
    logic rd_en;
    logic div_start;
    logic out_load;
    logic last_read;

    // Window bookkeeping for the incoming point.
    logic                 win_full;
    logic [CNT_W:0]       slot_sum;
    logic [IDX_W-1:0]     wr_slot;
    logic [CNT_W-1:0]     n_fill;
    logic [IDX_W-1:0]     n_oldest;
    logic [CNT_W-1:0]     k_plus1;
    logic [2*CNT_W-1:0]   k_sq;
    logic [POINT_W-1:0]   rd_point;
    logic                 div_done;
    t_coord_vec           div_res;

    assign win_full = (r_fill == CNT_W'(WINDOW));
    assign slot_sum = (CNT_W+1)'(r_oldest) + (CNT_W+1)'(r_fill);

    // Append after the newest point while filling; overwrite the oldest once full.
    always_comb begin
        if (win_full) begin
            wr_slot  = r_oldest;
            n_fill   = r_fill;
            n_oldest = slot_inc(r_oldest);
        end else begin
            wr_slot  = (slot_sum >= (CNT_W+1)'(WINDOW))
                     ? IDX_W'(slot_sum - (CNT_W+1)'(WINDOW))
                     : IDX_W'(slot_sum);
            n_fill   = CNT_W'(r_fill + 1'b1);
            n_oldest = r_oldest;
        end
    end

    assign last_read = (r_k == CNT_W'(r_fill - 1'b1));
    assign k_plus1   = CNT_W'(r_k + 1'b1);
    assign k_sq      = k_plus1 * k_plus1;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_beat) n_state = S_SCAN;
            S_SCAN:  if (last_read) n_state = S_DRAIN;
            S_DRAIN: if (!r_v1 && !r_v2) n_state = S_DIV;
            S_DIV:   if (div_done) n_state = S_LOAD;
            S_LOAD:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_in_stall = 1'b1;
        rd_en      = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            S_IDLE:  o_in_stall = 1'b0;
            S_SCAN:  rd_en = 1'b1;
            S_DRAIN: div_start = !r_v1 && !r_v2;
            S_DIV:   ;
            S_LOAD:  out_load = !r_out_valid || !i_out_stall;
            default: ;
        endcase
    end

    assign in_beat = i_in_valid && !o_in_stall;

    // Window storage: one point of three coordinates per slot.
    qwma_ram #(
        .WIDTH (POINT_W),
        .DEPTH (WINDOW)
    ) u_win_ram (
        .i_clk   (i_clk),
        .i_we    (in_beat),
        .i_waddr (wr_slot),
        .i_wdata ({i_sample_z, i_sample_y, i_sample_x}),
        .i_re    (rd_en),
        .i_raddr (r_rd_slot),
        .o_rdata (rd_point)
    );

    // Rounding divide by the weight total, one lane per axis.
    qwma_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_acc   (r_acc),
        .o_done  (div_done),
        .o_res   (div_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_oldest    <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= rd_en;
            r_v2    <= r_v1;
            if (in_beat) begin
                r_fill   <= n_fill;
                r_oldest <= n_oldest;
            end
            // Hold the result until the consumer takes the beat.
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Scan from the oldest point, weight (k+1)^2, multiply, then accumulate.
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_k       <= '0;
            r_rd_slot <= n_oldest;
        end else if (rd_en) begin
            r_k       <= k_plus1;
            r_rd_slot <= slot_inc(r_rd_slot);
        end
        r_w1 <= k_sq[WGT_W-1:0];
        if (r_v1) begin
            for (int c = 0; c < NUM_AXES; c++) begin
                r_prod[c] <= PROD_W'($signed(rd_point[c*COORD_W +: COORD_W])
                                     * $signed({1'b0, r_w1}));
            end
        end
        if (in_beat) begin
            r_acc <= '0;
        end else if (r_v2) begin
            for (int c = 0; c < NUM_AXES; c++) begin
                r_acc[c] <= ACC_W'(r_acc[c] + ACC_W'($signed(r_prod[c])));
            end
        end
        if (out_load) begin
            r_out <= div_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_smooth_x  = r_out[0];
    assign o_smooth_y  = r_out[1];
    assign o_smooth_z  = r_out[2];

endmodule

FILE: hw/rtl/qwma_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module qwma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/qwma_div.sv
// Three-lane rounding divider by the constant weight total, with 32-bit saturation.
// Depends on qwma_pkg.
`timescale 1ns / 1ps

module qwma_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  qwma_pkg::t_acc_vec    i_acc,
    output logic                  o_done,
    output qwma_pkg::t_coord_vec  o_res
);
    import qwma_pkg::*;

    localparam int PART_W = REM_W + 1;

    logic                            r_busy;
    logic                            r_done;
    logic [STEP_W-1:0]               r_step;
    logic [NUM_AXES-1:0]             r_neg;
    logic [NUM_AXES-1:0][REM_W-1:0]  r_rem;
    logic [NUM_AXES-1:0][COORD_W-1:0] r_low;
    logic [NUM_AXES-1:0][REM_W-1:0]  n_rem;
    logic [NUM_AXES-1:0][COORD_W-1:0] n_low;
    logic [NUM_AXES-1:0][DVD_W-1:0]  start_dvd;
    logic [NUM_AXES-1:0]             start_neg;
    logic                            last_step;

    assign last_step = (r_step == STEP_W'(DIV_STEPS - 1));

    // Magnitude plus half the divisor gives round-half-away-from-zero.
    always_comb begin
        logic [ACC_W-1:0] mag;
        for (int c = 0; c < NUM_AXES; c++) begin
            start_neg[c] = i_acc[c][ACC_W-1];
            mag          = start_neg[c] ? ACC_W'(-i_acc[c]) : i_acc[c];
            start_dvd[c] = DVD_W'(mag) + DVD_W'(HALF_WT);
        end
    end

    // Four restoring steps per cycle; quotient bits shift into the low word.
    always_comb begin
        logic [REM_W-1:0]   rem;
        logic [COORD_W-1:0] low;
        logic [PART_W-1:0]  part;
        for (int c = 0; c < NUM_AXES; c++) begin
            rem = r_rem[c];
            low = r_low[c];
            for (int i = 0; i < BITS_PER_STEP; i++) begin
                part = {rem, low[COORD_W-1]};
                low  = {low[COORD_W-2:0], 1'b0};
                if (part >= PART_W'(WTOTAL)) begin
                    rem    = REM_W'(part - PART_W'(WTOTAL));
                    low[0] = 1'b1;
                end else begin
                    rem = part[REM_W-1:0];
                end
            end
            n_rem[c] = rem;
            n_low[c] = low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && last_step;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= STEP_W'(r_step + 1'b1);
                if (last_step) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            for (int c = 0; c < NUM_AXES; c++) begin
                r_neg[c] <= start_neg[c];
                r_rem[c] <= start_dvd[c][DVD_W-1:COORD_W];
                r_low[c] <= start_dvd[c][COORD_W-1:0];
            end
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_low <= n_low;
        end
    end

    // Apply sign and clamp to the signed 32-bit range.
    always_comb begin
        for (int c = 0; c < NUM_AXES; c++) begin
            if (r_neg[c]) begin
                o_res[c] = (r_low[c] > {1'b1, {(COORD_W-1){1'b0}}})
                         ? {1'b1, {(COORD_W-1){1'b0}}}
                         : COORD_W'(-r_low[c]);
            end else begin
                o_res[c] = r_low[c][COORD_W-1] ? {1'b0, {(COORD_W-1){1'b1}}} : r_low[c];
            end
        end
    end

    assign o_done = r_done;

endmodule

FILE: hw/rtl/qwma_chk.sv
// Port-level checker for the quadratic weighted moving average top level, with its bind.
// Depends on qwma_pkg and quadratic_weighted_moving_average_3d_top.
`timescale 1ns / 1ps

module qwma_chk (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input qwma_pkg::t_coord o_smooth_x,
    input qwma_pkg::t_coord o_smooth_y,
    input qwma_pkg::t_coord o_smooth_z
);

    // A stalled result beat stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_smooth_x) && $stable(o_smooth_y) && $stable(o_smooth_z))
        else $error("result payload changed while stalled");

    // One item at a time: an accepted beat makes the block busy.
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after a beat");

    // A new result only appears at the end of work on an item.
    a_out_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared while idle");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("handshake not cleared by reset");

endmodule

bind quadratic_weighted_moving_average_3d_top qwma_chk u_qwma_chk (.*);

FILE: tb/sv/qwma_checker.sv
// Checker for the quadratic weighted moving average: watches the sample and smoothed beat
// channels, predicts each weighted average and compares it field by field. Uses qwma_pkg.
`timescale 1ns / 1ps

module qwma_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  qwma_pkg::t_coord i_sample_x,
    input  qwma_pkg::t_coord i_sample_y,
    input  qwma_pkg::t_coord i_sample_z,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  qwma_pkg::t_coord i_smooth_x,
    input  qwma_pkg::t_coord i_smooth_y,
    input  qwma_pkg::t_coord i_smooth_z,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);

    // Far more than the block can hold in flight.
    localparam int AVG_DEPTH = 8;

    typedef struct packed {
        qwma_pkg::t_coord x;
        qwma_pkg::t_coord y;
        qwma_pkg::t_coord z;
    } t_point;

    t_point window_pts [qwma_pkg::WINDOW];
    int     stored_cnt;
    int     oldest_idx;
    t_point avg_fifo [AVG_DEPTH];
    int     avg_rd;
    int     avg_wr;
    int     avg_cnt;

    // Divide by the full weight total, round half away from zero, clamp to 32 bits.
    function automatic qwma_pkg::t_coord round_by_total(input longint acc);
        longint total;
        longint mag;
        longint q;
        total = longint'(qwma_pkg::WTOTAL);
        mag   = (acc < 0) ? -acc : acc;
        q     = (mag + total / 2) / total;
        if (acc < 0) begin
            if (q > 64'sd2147483648) q = 64'sd2147483648;
            return qwma_pkg::t_coord'(-q);
        end
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        return qwma_pkg::t_coord'(q);
    endfunction

    // Store one point in the window and compute the weighted average it yields.
    task automatic take_point(input t_point p, output t_point avg);
        int     slot;
        int     s;
        int     k;
        longint w;
        longint ax;
        longint ay;
        longint az;
        if (stored_cnt < qwma_pkg::WINDOW) begin
            slot = (oldest_idx + stored_cnt) % qwma_pkg::WINDOW;
            stored_cnt++;
        end else begin
            slot = oldest_idx;
            oldest_idx = (oldest_idx + 1) % qwma_pkg::WINDOW;
        end
        window_pts[slot] = p;
        ax = 0;
        ay = 0;
        az = 0;
        for (k = 0; k < stored_cnt; k++) begin
            s  = (oldest_idx + k) % qwma_pkg::WINDOW;
            w  = longint'((k + 1) * (k + 1));
            ax += longint'($signed(window_pts[s].x)) * w;
            ay += longint'($signed(window_pts[s].y)) * w;
            az += longint'($signed(window_pts[s].z)) * w;
        end
        avg.x = round_by_total(ax);
        avg.y = round_by_total(ay);
        avg.z = round_by_total(az);
    endtask

    function automatic int field_mismatch(input string name, input qwma_pkg::t_coord want,
                                          input qwma_pkg::t_coord got);
        if (want === got) return 0;
        $error("%s: expected %0d, actual %0d", name, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin : watch
        t_point got;
        t_point want;
        t_point avg;
        t_point smp;
        if (!i_rst_n) begin
            stored_cnt   = 0;
            oldest_idx   = 0;
            avg_rd       = 0;
            avg_wr       = 0;
            avg_cnt      = 0;
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            // Check the result beat first: it always belongs to an older sample.
            if (i_out_valid && !i_out_stall) begin
                got.x = i_smooth_x;
                got.y = i_smooth_y;
                got.z = i_smooth_z;
                if (avg_cnt == 0) begin
                    $error("smoothed beat with no average pending");
                    o_fail_count++;
                end else begin
                    want   = avg_fifo[avg_rd];
                    avg_rd = (avg_rd + 1) % AVG_DEPTH;
                    avg_cnt--;
                    o_checked++;
                    o_fail_count += field_mismatch("smooth_x", want.x, got.x);
                    o_fail_count += field_mismatch("smooth_y", want.y, got.y);
                    o_fail_count += field_mismatch("smooth_z", want.z, got.z);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                smp.x = i_sample_x;
                smp.y = i_sample_y;
                smp.z = i_sample_z;
                take_point(smp, avg);
                if (avg_cnt == AVG_DEPTH) begin
                    $error("too many averages pending");
                    o_fail_count++;
                end else begin
                    avg_fifo[avg_wr] = avg;
                    avg_wr = (avg_wr + 1) % AVG_DEPTH;
                    avg_cnt++;
                end
            end
        end
        o_pending = avg_cnt;
    end

endmodule

FILE: tb/sv/tb_quadratic_weighted_moving_average_3d_top.sv
// Testbench top for the quadratic weighted moving average block: drives sample beats,
// stalls the result side and gives the verdict. Uses qwma_pkg and qwma_checker.
`timescale 1ns / 1ps

module tb_quadratic_weighted_moving_average_3d_top;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_POINTS = 750;
    localparam int DIRECTED_PTS  = 22;
    localparam int DRAIN_CYCLES  = 64;      // a full window plus the divider, with margin

    localparam qwma_pkg::t_coord CMAX = 32'sh7FFF_FFFF;
    localparam qwma_pkg::t_coord CMIN = 32'sh8000_0000;

    logic             i_clk;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_stall;
    qwma_pkg::t_coord i_sample_x  = '0;
    qwma_pkg::t_coord i_sample_y  = '0;
    qwma_pkg::t_coord i_sample_z  = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    qwma_pkg::t_coord o_smooth_x;
    qwma_pkg::t_coord o_smooth_y;
    qwma_pkg::t_coord o_smooth_z;

    // Quiet stretch: while set, neither side idles.
    logic quiet = 1'b0;

    int fail_count;
    int pending;
    int checked;
    int sent = 0;

    quadratic_weighted_moving_average_3d_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample_x  (i_sample_x),
        .i_sample_y  (i_sample_y),
        .i_sample_z  (i_sample_z),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_smooth_x  (o_smooth_x),
        .o_smooth_y  (o_smooth_y),
        .o_smooth_z  (o_smooth_z)
    );

    qwma_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_sample_x   (i_sample_x),
        .i_sample_y   (i_sample_y),
        .i_sample_z   (i_sample_z),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_smooth_x   (o_smooth_x),
        .i_smooth_y   (o_smooth_y),
        .i_smooth_z   (o_smooth_z),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Bound the run: a hang anywhere ends here.
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("tb_quadratic_weighted_moving_average_3d_top: FAIL");
        $finish;
    end

    // Stall the result side at random, about 27 percent of the time, except in the quiet stretch.
    always @(negedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < 27);
        end
    end

    // Drive one sample beat; enter and leave at a falling edge. Idle at random first,
    // then hold the payload until the block takes it.
    task automatic send_point(input qwma_pkg::t_coord x, input qwma_pkg::t_coord y,
                              input qwma_pkg::t_coord z);
        while (!quiet && $urandom_range(99) < 27) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample_x <= x;
        i_sample_y <= y;
        i_sample_z <= z;
        do @(posedge i_clk); while (o_in_stall);
        sent++;
        @(negedge i_clk);
    endtask

    // Drop valid and hold off until every pending average has come back.
    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    // Mix full-range values with extremes, values near rounding ties, and small positions.
    function automatic qwma_pkg::t_coord rand_coord();
        case ($urandom_range(9)) inside
            0: begin
                case ($urandom_range(4))
                    0: return CMAX;
                    1: return CMIN;
                    2: return '0;
                    3: return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
            [1:2]: return qwma_pkg::t_coord'(int'($urandom_range(5740)) - 2870);
            3: return qwma_pkg::t_coord'(int'($urandom_range(32'h00FF_FFFF)) - 32'h0080_0000);
            default: return qwma_pkg::t_coord'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        int               n;
        qwma_pkg::t_coord px;
        qwma_pkg::t_coord py;
        qwma_pkg::t_coord pz;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: a rounding tie on a lone point (both signs, and one just below),
        // the field extremes while the window fills, then wrap past twenty points.
        send_point(32'sd1435, -32'sd1435, 32'sd1434);
        send_point('0, '0, '0);
        send_point(CMAX, CMIN, -32'sd1);
        send_point(CMIN, CMAX, 32'sd1);
        send_point(CMAX, CMAX, CMAX);
        send_point(CMIN, CMIN, CMIN);
        send_point(-32'sd1, 32'sd1, '0);
        send_point(32'sh0001_0000, -32'sh0001_0000, 32'sh7FFF_0000);
        for (n = 0; n < DIRECTED_PTS - 8; n++) begin
            send_point(CMAX, CMIN, (n % 2) ? CMAX : CMIN);
        end
        hold_until_drained();

        // Random: about one point in ten repeats the previous one to hold a steady window.
        px = '0;
        py = '0;
        pz = '0;
        for (n = 0; n < RANDOM_POINTS; n++) begin
            quiet = (n >= 300 && n < 450);
            if (n == 500) hold_until_drained();
            if ($urandom_range(9) != 0) begin
                px = rand_coord();
                py = rand_coord();
                pz = rand_coord();
            end
            send_point(px, py, pz);
        end
        quiet = 1'b0;

        // Wind down: wait for the last averages, then let the block settle.
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d points: %0d directed (extremes, rounding tie, fill and wrap), %0d %s",
                 sent, DIRECTED_PTS, sent - DIRECTED_PTS, "random.");
        $display("Checked %0d averages under random idling on both ends, %s",
                 checked, "a quiet stretch and drain pauses.");
        if (fail_count == 0) begin
            $display("tb_quadratic_weighted_moving_average_3d_top: PASS");
        end else begin
            $display("tb_quadratic_weighted_moving_average_3d_top: FAIL");
        end
        $finish;
    end

endmodule
